@@ rtl/bgm_pkg.sv @@
package bgm_pkg;

    localparam int unsigned NUM_VERTICES_DEF = 64;
    localparam int unsigned OP_W             = 2;
    localparam int unsigned VID_W            = 6;
    localparam int unsigned ST_W             = 3;
    // vertex ids are VID_W bits wide, so no more rows than this can be addressed
    localparam int unsigned VID_LIM          = 2 ** VID_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_VERTEX = 2'd0,
        OP_ADD_EDGE   = 2'd1,
        OP_DEL_VERTEX = 2'd2,
        OP_DEL_EDGE   = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK             = 3'd0,
        ST_VERTEX_EXISTS  = 3'd1,
        ST_VERTEX_MISSING = 3'd2,
        ST_BAD_ENDPOINTS  = 3'd3,
        ST_EDGE_EXISTS    = 3'd4,
        ST_ODD_CYCLE      = 3'd5,
        ST_EDGE_MISSING   = 3'd6
    } t_status;

    // read address source
    typedef enum logic [1:0] {
        RD_IN   = 2'd0,
        RD_A    = 2'd1,
        RD_B    = 2'd2,
        RD_SCAN = 2'd3
    } t_rd_sel;

    // row update kinds
    typedef enum logic [2:0] {
        WR_A_ADD  = 3'd0,
        WR_A_DEL  = 3'd1,
        WR_A_ZERO = 3'd2,
        WR_B_ADD  = 3'd3,
        WR_B_DEL  = 3'd4
    } t_wr_kind;

    // what a scan read feeds
    typedef enum logic [1:0] {
        SCAN_BFS   = 2'd0,
        SCAN_CHK   = 2'd1,
        SCAN_SWEEP = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_kind   wr_kind;
        logic       cap_a;
        logic       set_pres;
        logic       clr_pres;
        logic       bfs_init;
        logic       level_end;
        logic       chk_init;
        logic       sweep_init;
        logic       scan;
        t_scan_mode scan_mode;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    a_in;
        logic    a_ok;
        logic    b_ok;
        logic    a_eq_b;
        logic    edge_ab;
        logic    pend_nz;
        logic    lvl_empty;
        logic    odd;
    } t_dp_stat;

endpackage

@@ rtl/bgm_if.sv @@
interface bgm_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [bgm_pkg::OP_W-1:0]   opcode;
    logic [bgm_pkg::VID_W-1:0]  vertex_a;
    logic [bgm_pkg::VID_W-1:0]  vertex_b;

    modport source (output valid, output opcode, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input opcode, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface bgm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bgm_pkg::ST_W-1:0]   status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

@@ rtl/bgm_datapath.sv @@
module bgm_datapath #(
    parameter int unsigned NUM_VERTICES = bgm_pkg::NUM_VERTICES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bgm_pkg::t_dp_cmd           i_cmd,
    input  logic [bgm_pkg::OP_W-1:0]   i_opcode,
    input  logic [bgm_pkg::VID_W-1:0]  i_vertex_a,
    input  logic [bgm_pkg::VID_W-1:0]  i_vertex_b,
    output bgm_pkg::t_dp_stat          o_stat
);
    import bgm_pkg::*;

    localparam int unsigned VCNT = (NUM_VERTICES < VID_LIM) ? NUM_VERTICES : VID_LIM;
    localparam int unsigned AW   = $clog2(VCNT);

    typedef logic [VCNT-1:0] t_row;
    typedef logic [AW-1:0]   t_idx;

    // command latch
    t_opcode            r_op;
    logic [VID_W-1:0]   r_va;
    logic [VID_W-1:0]   r_vb;

    // graph storage
    t_row               r_pres;
    t_row               r_row_vld;
    t_row               r_adj [VCNT];
    t_row               r_rd_raw;
    logic               r_rd_ok;
    t_idx               r_rd_idx;
    t_row               r_row_a;

    // search scratch
    logic               r_scan_v;
    t_scan_mode         r_scan_mode;
    t_row               r_pend;
    t_row               r_next;
    t_row               r_reached;
    t_row               r_color;
    logic               r_parity;
    logic               r_odd;

    logic       a_in, b_in;
    t_idx       a_idx, b_idx, pick_idx, rd_addr, wr_addr;
    t_row       bit_a, bit_b, rd_row, eff_row, same_side, acc_next, lvl_next, wr_data;
    logic       pend_nz, issue, rd_en, wr_en;
    logic       ab_bfs, ab_chk, ab_sweep, odd_acc;

    assign a_in  = (32'(r_va) < VCNT);
    assign b_in  = (32'(r_vb) < VCNT);
    assign a_idx = r_va[AW-1:0];
    assign b_idx = r_vb[AW-1:0];
    assign bit_a = t_row'(1) << a_idx;
    assign bit_b = t_row'(1) << b_idx;

    assign rd_row = r_rd_ok ? r_rd_raw : '0;
    // the edge under test is seen by the search without being stored yet
    assign eff_row = rd_row
                   | ((r_rd_idx == b_idx) ? bit_a : '0)
                   | ((r_rd_idx == a_idx) ? bit_b : '0);

    // lowest pending vertex
    always_comb begin
        pick_idx = '0;
        for (int i = VCNT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pick_idx = t_idx'(i);
            end
        end
    end

    assign pend_nz = |r_pend;
    assign issue   = i_cmd.scan && pend_nz;
    assign rd_en   = i_cmd.rd_en || issue;

    always_comb begin
        if (issue) begin
            rd_addr = pick_idx;
        end else begin
            unique case (i_cmd.rd_sel)
                RD_IN:   rd_addr = i_vertex_a[AW-1:0];
                RD_A:    rd_addr = a_idx;
                RD_B:    rd_addr = b_idx;
                RD_SCAN: rd_addr = pick_idx;
            endcase
        end
    end

    assign ab_bfs   = r_scan_v && (r_scan_mode == SCAN_BFS);
    assign ab_chk   = r_scan_v && (r_scan_mode == SCAN_CHK);
    assign ab_sweep = r_scan_v && (r_scan_mode == SCAN_SWEEP);

    assign acc_next  = r_next | (ab_bfs ? eff_row : '0);
    assign lvl_next  = acc_next & ~r_reached;
    assign same_side = r_color[r_rd_idx] ? r_color : ~r_color;
    assign odd_acc   = r_odd || (ab_chk && (|(eff_row & r_reached & same_side)));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = a_idx;
        wr_data = '0;
        if (ab_sweep) begin
            // drop the deleted vertex from a neighbor row
            wr_en   = 1'b1;
            wr_addr = r_rd_idx;
            wr_data = rd_row & ~bit_a;
        end else if (i_cmd.wr_en) begin
            wr_en = 1'b1;
            case (i_cmd.wr_kind)
                WR_A_ADD: begin
                    wr_addr = a_idx;
                    wr_data = r_row_a | bit_b;
                end
                WR_A_DEL: begin
                    wr_addr = a_idx;
                    wr_data = r_row_a & ~bit_b;
                end
                WR_A_ZERO: begin
                    wr_addr = a_idx;
                    wr_data = '0;
                end
                WR_B_ADD: begin
                    wr_addr = b_idx;
                    wr_data = rd_row | bit_a;
                end
                WR_B_DEL: begin
                    wr_addr = b_idx;
                    wr_data = rd_row & ~bit_a;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // adjacency rows, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_adj[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_raw <= r_adj[rd_addr];
            r_rd_ok  <= r_row_vld[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_pres    <= '0;
            r_scan_v  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.set_pres) begin
                r_pres[a_idx] <= 1'b1;
            end else if (i_cmd.clr_pres) begin
                r_pres[a_idx] <= 1'b0;
            end
            r_scan_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_mode <= i_cmd.scan_mode;
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_opcode);
            r_va <= i_vertex_a;
            r_vb <= i_vertex_b;
        end
        if (i_cmd.cap_a) begin
            r_row_a <= rd_row;
        end

        priority if (i_cmd.bfs_init) begin
            r_reached <= bit_a;
            r_pend    <= bit_a;
            r_color   <= '0;
            r_parity  <= 1'b0;
            r_next    <= '0;
        end else if (i_cmd.level_end) begin
            // odd levels take the other side
            if (!r_parity) begin
                r_color <= r_color | lvl_next;
            end
            r_parity  <= ~r_parity;
            r_reached <= r_reached | lvl_next;
            r_pend    <= lvl_next;
            r_next    <= '0;
        end else if (i_cmd.chk_init) begin
            r_pend <= r_reached;
        end else if (i_cmd.sweep_init) begin
            r_pend <= rd_row;
        end else begin
            r_next <= acc_next;
            if (issue) begin
                r_pend <= r_pend & (r_pend - t_row'(1));
            end
        end

        if (i_cmd.chk_init) begin
            r_odd <= 1'b0;
        end else begin
            r_odd <= odd_acc;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.a_in      = a_in;
    assign o_stat.a_ok      = a_in && r_pres[a_idx];
    assign o_stat.b_ok      = b_in && r_pres[b_idx];
    assign o_stat.a_eq_b    = (r_va == r_vb);
    assign o_stat.edge_ab   = a_in && b_in && rd_row[b_idx];
    assign o_stat.pend_nz   = pend_nz;
    assign o_stat.lvl_empty = (lvl_next == '0);
    assign o_stat.odd       = odd_acc;

endmodule

@@ rtl/bgm_ctrl.sv @@
module bgm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output logic [bgm_pkg::ST_W-1:0]  o_status,
    input  logic                      i_out_ready,
    output bgm_pkg::t_dp_cmd          o_cmd,
    input  bgm_pkg::t_dp_stat         i_stat
);
    import bgm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_BFS,
        S_LVL,
        S_CHK_INIT,
        S_CHK,
        S_CHK_END,
        S_CMT_B,
        S_DEL,
        S_EDEL_A,
        S_EDEL_B,
        S_DONE
    } t_state;

    t_state   r_state, n_state;
    t_status  r_status;
    logic     r_out_valid;
    t_status  r_out_status;

    logic     fin, slot_free, out_load;
    t_status  fin_status, out_status;
    t_dp_cmd  cmd;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign out_load   = (fin || (r_state == S_DONE)) && slot_free;
    assign out_status = (r_state == S_DONE) ? r_status : fin_status;

    always_comb begin
        cmd        = '0;
        fin        = 1'b0;
        fin_status = ST_OK;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load   = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IN;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.cap_a = 1'b1;
                unique case (i_stat.op)
                    OP_INS_VERTEX: begin
                        fin = 1'b1;
                        priority if (!i_stat.a_in) begin
                            fin_status = ST_VERTEX_MISSING;
                        end else if (i_stat.a_ok) begin
                            fin_status = ST_VERTEX_EXISTS;
                        end else begin
                            cmd.set_pres = 1'b1;
                        end
                    end
                    OP_ADD_EDGE: begin
                        priority if (!(i_stat.a_ok && i_stat.b_ok)) begin
                            fin        = 1'b1;
                            fin_status = ST_VERTEX_MISSING;
                        end else if (i_stat.a_eq_b) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD_ENDPOINTS;
                        end else if (i_stat.edge_ab) begin
                            fin        = 1'b1;
                            fin_status = ST_EDGE_EXISTS;
                        end else begin
                            cmd.bfs_init = 1'b1;
                            n_state      = S_BFS;
                        end
                    end
                    OP_DEL_VERTEX: begin
                        if (!i_stat.a_ok) begin
                            fin        = 1'b1;
                            fin_status = ST_VERTEX_MISSING;
                        end else begin
                            cmd.clr_pres   = 1'b1;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_kind    = WR_A_ZERO;
                            cmd.sweep_init = 1'b1;
                            n_state        = S_DEL;
                        end
                    end
                    OP_DEL_EDGE: begin
                        if (!i_stat.edge_ab) begin
                            fin        = 1'b1;
                            fin_status = ST_EDGE_MISSING;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_B;
                            n_state    = S_EDEL_A;
                        end
                    end
                endcase
            end
            S_BFS: begin
                cmd.scan      = 1'b1;
                cmd.scan_mode = SCAN_BFS;
                if (!i_stat.pend_nz) begin
                    n_state = S_LVL;
                end
            end
            S_LVL: begin
                cmd.level_end = 1'b1;
                n_state = i_stat.lvl_empty ? S_CHK_INIT : S_BFS;
            end
            S_CHK_INIT: begin
                cmd.chk_init = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                cmd.scan      = 1'b1;
                cmd.scan_mode = SCAN_CHK;
                if (!i_stat.pend_nz) begin
                    n_state = S_CHK_END;
                end
            end
            S_CHK_END: begin
                if (i_stat.odd) begin
                    fin        = 1'b1;
                    fin_status = ST_ODD_CYCLE;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_kind = WR_A_ADD;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_B;
                    n_state     = S_CMT_B;
                end
            end
            S_CMT_B: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_kind = WR_B_ADD;
                fin         = 1'b1;
            end
            S_DEL: begin
                cmd.scan      = 1'b1;
                cmd.scan_mode = SCAN_SWEEP;
                if (!i_stat.pend_nz) begin
                    fin = 1'b1;
                end
            end
            S_EDEL_A: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_kind = WR_A_DEL;
                n_state     = S_EDEL_B;
            end
            S_EDEL_B: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_kind = WR_B_DEL;
                fin         = 1'b1;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
        if (fin) begin
            n_state = slot_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin) begin
                r_status <= fin_status;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= out_status;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

@@ rtl/bipartite_graph_maintainer_unit.sv @@
// bipartite graph maintainer
// i_cmd carries one command per transfer: opcode, vertex_a, vertex_b
// (insert vertex, add edge, delete vertex, delete edge). o_rsp returns exactly
// one status code per command, in command order.
// commands run one at a time; the command port is ready only while the
// controller is idle. insert vertex and every command turned away by its
// first checks finish in the decode step after the row read at accept;
// delete edge then writes the row of vertex_a and then that of vertex_b,
// delete vertex clears its own row and sweeps the row of every neighbor.
// add edge walks the component of vertex_a level by level, one adjacency row
// read per cycle from the single-read-port row memory, then reads every
// reached row once more for the color check.
// the result sits in an output register, so the next command is accepted
// while it waits; if the receiver stalls and a second result is ready the
// controller holds in a done state until the register drains.
// reset (synchronous, active low) empties the vertex set and marks every
// adjacency row as empty through per-row valid bits, so the block takes
// commands straight after reset with no clearing pass.
module bipartite_graph_maintainer_unit #(
    parameter int unsigned NUM_VERTICES = bgm_pkg::NUM_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgm_cmd_if.sink    i_cmd,
    bgm_rsp_if.source  o_rsp
);
    import bgm_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic              in_ready;
    logic              out_valid;
    logic [ST_W-1:0]   out_status;

    // sequencer: command decode, level loop, check and commit steps
    bgm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_status    (out_status),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // row memory, vertex bitmap and the bit-parallel search registers
    bgm_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_opcode   (i_cmd.opcode),
        .i_vertex_a (i_cmd.vertex_a),
        .i_vertex_b (i_cmd.vertex_b),
        .o_stat     (dp_stat)
    );

    assign i_cmd.ready  = in_ready;
    assign o_rsp.valid  = out_valid;
    assign o_rsp.status = out_status;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bgm_pkg::*;

    localparam int unsigned NV          = NUM_VERTICES_DEF;
    localparam logic [63:0] LIVE_MASK   = (NV >= 64) ? '1 : ((64'd1 << NV) - 64'd1);
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 300;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 143;

    typedef struct packed {
        t_opcode          op;
        logic [VID_W-1:0] va;
        logic [VID_W-1:0] vb;
        logic             fixed;
        t_status          st;
    } t_cmd_row;

    // opening sequence; st is only meaningful where fixed is set
    localparam t_cmd_row OPENING_ROWS [0:24] = '{
        '{OP_DEL_EDGE,   6'd0,  6'd63, 1'b1, ST_EDGE_MISSING},
        '{OP_DEL_VERTEX, 6'd63, 6'd0,  1'b1, ST_VERTEX_MISSING},
        '{OP_ADD_EDGE,   6'd0,  6'd63, 1'b1, ST_VERTEX_MISSING},
        '{OP_INS_VERTEX, 6'd0,  6'd63, 1'b1, ST_OK},
        '{OP_INS_VERTEX, 6'd0,  6'd0,  1'b1, ST_VERTEX_EXISTS},
        '{OP_INS_VERTEX, 6'd63, 6'd0,  1'b1, ST_OK},
        '{OP_ADD_EDGE,   6'd0,  6'd0,  1'b1, ST_BAD_ENDPOINTS},
        '{OP_ADD_EDGE,   6'd0,  6'd62, 1'b1, ST_VERTEX_MISSING},
        '{OP_ADD_EDGE,   6'd62, 6'd63, 1'b1, ST_VERTEX_MISSING},
        '{OP_ADD_EDGE,   6'd0,  6'd63, 1'b0, ST_OK},
        '{OP_ADD_EDGE,   6'd63, 6'd0,  1'b1, ST_EDGE_EXISTS},
        '{OP_INS_VERTEX, 6'd42, 6'd63, 1'b0, ST_OK},
        '{OP_INS_VERTEX, 6'd21, 6'd42, 1'b0, ST_OK},
        '{OP_ADD_EDGE,   6'd63, 6'd42, 1'b0, ST_OK},
        '{OP_ADD_EDGE,   6'd42, 6'd0,  1'b0, ST_OK},   // triangle
        '{OP_ADD_EDGE,   6'd21, 6'd42, 1'b0, ST_OK},
        '{OP_ADD_EDGE,   6'd21, 6'd0,  1'b0, ST_OK},   // closes an even cycle
        '{OP_ADD_EDGE,   6'd21, 6'd63, 1'b0, ST_OK},   // chord making odd cycle
        '{OP_DEL_EDGE,   6'd42, 6'd21, 1'b0, ST_OK},
        '{OP_DEL_EDGE,   6'd42, 6'd21, 1'b1, ST_EDGE_MISSING},
        '{OP_DEL_VERTEX, 6'd0,  6'd21, 1'b0, ST_OK},   // takes its edges along
        '{OP_ADD_EDGE,   6'd63, 6'd21, 1'b0, ST_OK},
        '{OP_DEL_VERTEX, 6'd0,  6'd0,  1'b1, ST_VERTEX_MISSING},
        '{OP_DEL_EDGE,   6'd0,  6'd63, 1'b1, ST_EDGE_MISSING},
        '{OP_INS_VERTEX, 6'd63, 6'd42, 1'b1, ST_VERTEX_EXISTS}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bgm_cmd_if cmd_ch ();
    bgm_rsp_if rsp_ch ();

    bipartite_graph_maintainer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    // shadow graph, advanced at every command transfer
    logic [63:0] vertex_mask;
    logic [63:0] adj_rows [64];

    t_status pending_status [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;

    // random shaping, set per phase by the stimulus process
    int hot_base      = 0;
    int hot_span      = 16;
    bit send_idle_on  = 1'b1;
    bit recv_stall_on = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    function automatic bit vertex_live(input logic [5:0] v);
        return (v < NV) && vertex_mask[v];
    endfunction

    // level-parity coloring of the component holding start
    function automatic bit component_two_colorable(input logic [5:0] start);
        logic [63:0] seen;
        logic [63:0] front;
        logic [63:0] grow;
        logic [63:0] side;
        logic [63:0] same;
        int          lvl;
        seen  = 64'd1 << start;
        front = 64'd1 << start;
        side  = '0;
        lvl   = 0;
        while (front != 0 && lvl < 64) begin
            grow = '0;
            for (int v = 0; v < 64; v++)
                if (front[v])
                    grow |= adj_rows[v];
            grow &= ~seen & LIVE_MASK;
            lvl++;
            if (lvl % 2 == 1)
                side |= grow;
            seen |= grow;
            front = grow;
        end
        for (int v = 0; v < 64; v++) begin
            if (seen[v]) begin
                same = side[v] ? side : ~side;
                if ((adj_rows[v] & seen & same) != 0)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_status apply_graph_cmd(input t_opcode op, input logic [5:0] a,
                                                input logic [5:0] b);
        t_status st;
        st = ST_OK;
        case (op)
            OP_INS_VERTEX: begin
                if (a >= NV)
                    st = ST_VERTEX_MISSING;
                else if (vertex_mask[a])
                    st = ST_VERTEX_EXISTS;
                else
                    vertex_mask[a] = 1'b1;
            end
            OP_ADD_EDGE: begin
                if (!vertex_live(a) || !vertex_live(b))
                    st = ST_VERTEX_MISSING;
                else if (a == b)
                    st = ST_BAD_ENDPOINTS;
                else if (adj_rows[a][b])
                    st = ST_EDGE_EXISTS;
                else begin
                    // tentative insert, pulled back if the coloring fails
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                    if (!component_two_colorable(a)) begin
                        adj_rows[a][b] = 1'b0;
                        adj_rows[b][a] = 1'b0;
                        st = ST_ODD_CYCLE;
                    end
                end
            end
            OP_DEL_VERTEX: begin
                if (!vertex_live(a))
                    st = ST_VERTEX_MISSING;
                else begin
                    vertex_mask[a] = 1'b0;
                    adj_rows[a] = '0;
                    for (int v = 0; v < 64; v++)
                        adj_rows[v][a] = 1'b0;
                end
            end
            default: begin
                if (!adj_rows[a][b])
                    st = ST_EDGE_MISSING;
                else begin
                    adj_rows[a][b] = 1'b0;
                    adj_rows[b][a] = 1'b0;
                end
            end
        endcase
        return st;
    endfunction

    // mostly from the hot window so that commands hit live vertices
    function automatic logic [5:0] any_id();
        if ($urandom_range(0, 4) == 0)
            return 6'($urandom_range(0, 63));
        return 6'(hot_base + $urandom_range(0, hot_span - 1));
    endfunction

    function automatic logic [5:0] live_id();
        logic [5:0] v;
        for (int k = 0; k < 12; k++) begin
            v = any_id();
            if (vertex_live(v))
                return v;
        end
        return any_id();
    endfunction

    function automatic logic [5:0] neighbor_of(input logic [5:0] v);
        int s;
        s = $urandom_range(0, 63);
        for (int k = 0; k < 64; k++)
            if (adj_rows[v][(s + k) % 64])
                return 6'((s + k) % 64);
        return any_id();
    endfunction

    // one command transfer; the shadow graph moves at the accepting edge
    task automatic send_cmd(input t_opcode op, input logic [5:0] a, input logic [5:0] b,
                            input bit fixed, input t_status fixed_st);
        t_status st;
        if (send_idle_on && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.opcode   <= op;
        cmd_ch.vertex_a <= a;
        cmd_ch.vertex_b <= b;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        st = apply_graph_cmd(op, a, b);
        pending_status.push_back(fixed ? fixed_st : st);
    endtask

    // response side: check each transfer, then decide ready for the next cycle
    initial begin
        t_status want;
        int      stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_status.size() == 0)
                    report_mismatch($sformatf("status %0d with no command outstanding",
                                              rsp_ch.status));
                else begin
                    want = pending_status.pop_front();
                    if (rsp_ch.status !== want)
                        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                                  rsp_ch.status, want, want.name()));
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (recv_stall_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** bipartite_graph_maintainer_unit: FAILED **");
        $finish;
    end

    // stimulus
    initial begin
        t_opcode    op;
        logic [5:0] va;
        logic [5:0] vb;
        int         pick;
        cmd_ch.valid    = 1'b0;
        cmd_ch.opcode   = OP_INS_VERTEX;
        cmd_ch.vertex_a = '0;
        cmd_ch.vertex_b = '0;
        vertex_mask     = '0;
        for (int v = 0; v < 64; v++)
            adj_rows[v] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening: empty graph, error codes, odd and even cycles
        for (int r = 0; r < 25; r++)
            send_cmd(OPENING_ROWS[r].op, OPENING_ROWS[r].va, OPENING_ROWS[r].vb,
                     OPENING_ROWS[r].fixed, OPENING_ROWS[r].st);

        // random phases; one spans all ids so components get large
        for (int phase = 0; phase < PHASES; phase++) begin
            hot_span      = (phase == 4) ? 64 : $urandom_range(8, 20);
            hot_base      = $urandom_range(0, 64 - hot_span);
            send_idle_on  = (phase != PHASES - 1) && (phase % 3 != 1);
            recv_stall_on = (phase != PHASES - 1) && (phase % 4 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                va   = any_id();
                vb   = any_id();
                if (pick < 20) begin
                    op = OP_INS_VERTEX;
                end else if (pick < 62) begin
                    op = OP_ADD_EDGE;
                    if ($urandom_range(0, 4) != 0) begin
                        va = live_id();
                        vb = live_id();
                    end
                end else if (pick < 70) begin
                    op = OP_DEL_VERTEX;
                    if ($urandom_range(0, 3) != 0)
                        va = live_id();
                end else if (pick < 90) begin
                    op = OP_DEL_EDGE;
                    if ($urandom_range(0, 4) < 3) begin
                        va = live_id();
                        vb = neighbor_of(va);
                    end
                end else begin
                    // noise: anything the fields allow
                    op = t_opcode'($urandom_range(0, 3));
                    va = 6'($urandom_range(0, 63));
                    vb = 6'($urandom_range(0, 63));
                end
                send_cmd(op, va, vb, 1'b0, ST_OK);
            end
        end
        cmd_ch.valid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("** bipartite_graph_maintainer_unit: PASSED **");
        else
            $display("** bipartite_graph_maintainer_unit: FAILED **");
        $finish;
    end

endmodule
